// ===== rtl/core/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel speed package
// Shared widths, register indexes and reset values for the wheel speed block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  localparam int unsigned FieldBits = 24;
  localparam int unsigned TickBitsDefault = 24;
  localparam int unsigned CfgIdxBits = 1;

  localparam logic [CfgIdxBits-1:0] RegSpeedNumerator = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegMinInterval = 1'd1;

  localparam logic [FieldBits-1:0] SpeedNumeratorReset = 24'd244183;
  localparam logic [FieldBits-1:0] MinIntervalReset = 24'd16384;
  localparam logic [FieldBits-1:0] SpeedMax = 24'hFFFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/wsp_divider.sv =====
// ----------------------------------------------------------------------------
// Wheel speed divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_divider #(
  parameter int unsigned TICK_BITS = wsp_pkg::TickBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [wsp_pkg::FieldBits-1:0] dividend_i,
  input  wire logic [TICK_BITS-1:0]          divisor_i,
  output logic                               done_o,
  output logic [wsp_pkg::FieldBits-1:0]      quotient_o
);

  localparam int unsigned N = wsp_pkg::FieldBits;
  localparam int unsigned CntBits = $clog2(N);
  localparam logic [CntBits-1:0] CntLast = CntBits'(N - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [N-1:0]         quo_q, quo_d;
  logic [TICK_BITS-1:0] rem_q, rem_d;
  logic [TICK_BITS-1:0] div_q, div_d;
  logic [TICK_BITS:0]   rem_sh;
  logic [TICK_BITS:0]   rem_sub;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[N-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[N-2:0], ge};
      rem_d = ge ? rem_sub[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/wheel_speed_from_edge_period.sv =====
// ----------------------------------------------------------------------------
// Wheel speed from edge period
// Turns wheel-sensor edge timestamps into speed reports in km/h.
// ----------------------------------------------------------------------------
// Each input item carries the tick counter value of one sensor edge. The
// period to the previous edge divides the speed numerator register, and a
// speed is reported when at least min_interval ticks have passed since the
// last report and the speed has changed. An edge yields zero or one item.
// An item that needs a division passes through the restoring divider, which
// forms one quotient bit per cycle, then through the result step to the
// output register, and the next edge is accepted once the block is idle again.
// An item with a zero period skips the divider and takes the maximum speed;
// an item that fails the interval test leaves the block idle and does not
// stall the input. One item is processed at a time, and edge_stall_o is high
// while it is. A finished item waits in the output register while
// speed_stall_i is high; the next edge is still accepted and held back only
// at its own result step. Reset clears the stored edge time, report time and
// speed to zero and loads the register defaults. Unknown cfg indexes are ignored.
// Configuration is written through the cfg_* port while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_from_edge_period #(
  parameter int unsigned TICK_BITS = wsp_pkg::TickBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wsp_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [wsp_pkg::FieldBits-1:0]  cfg_data_i,
  input  wire logic                           edge_valid_i,
  output logic                                edge_stall_o,
  input  wire logic [wsp_pkg::FieldBits-1:0]  edge_time_i,
  output logic                                speed_valid_o,
  input  wire logic                           speed_stall_i,
  output logic [wsp_pkg::FieldBits-1:0]       wheel_kmh_o
);

  localparam int unsigned FB = wsp_pkg::FieldBits;
  localparam int unsigned WideBits = TICK_BITS + FB;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StResult = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [FB-1:0]        numerator_q;
  logic [FB-1:0]        min_interval_q;
  logic [TICK_BITS-1:0] prev_edge_q;
  logic [TICK_BITS-1:0] last_report_q;
  logic [FB-1:0]        last_speed_q;
  logic [TICK_BITS-1:0] now_q;
  logic [FB-1:0]        speed_q, speed_d;
  logic                 out_valid_q;
  logic [FB-1:0]        out_data_q;

  logic                 accept;
  logic [WideBits-1:0]  edge_wide;
  logic [TICK_BITS-1:0] now;
  logic [TICK_BITS-1:0] period;
  logic [TICK_BITS-1:0] elapsed;
  logic                 interval_ok;
  logic                 out_free;
  logic                 report;
  logic                 div_start;
  logic                 div_done;
  logic [FB-1:0]        div_quotient;

  assign edge_wide = {{TICK_BITS{1'b0}}, edge_time_i};
  assign now = edge_wide[TICK_BITS-1:0];
  assign period = now - prev_edge_q;
  assign elapsed = now - last_report_q;
  assign interval_ok = {{FB{1'b0}}, elapsed} >= {{TICK_BITS{1'b0}}, min_interval_q};

  assign edge_stall_o = (state_q != StIdle);
  assign accept = edge_valid_i && !edge_stall_o;
  assign out_free = !out_valid_q || !speed_stall_i;
  assign report = (state_q == StResult) && out_free && (speed_q != last_speed_q);
  assign div_start = accept && interval_ok && (period != '0);

  wsp_divider #(
    .TICK_BITS(TICK_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(numerator_q),
    .divisor_i (period),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  always_comb begin
    state_d = state_q;
    speed_d = speed_q;
    case (state_q)
      StIdle: begin
        if (accept && interval_ok) begin
          if (period == '0) begin
            speed_d = wsp_pkg::SpeedMax;
            state_d = StResult;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          speed_d = div_quotient;
          state_d = StResult;
        end
      end
      StResult: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      numerator_q <= wsp_pkg::SpeedNumeratorReset;
      min_interval_q <= wsp_pkg::MinIntervalReset;
      prev_edge_q <= '0;
      last_report_q <= '0;
      last_speed_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          wsp_pkg::RegSpeedNumerator: numerator_q <= cfg_data_i;
          wsp_pkg::RegMinInterval: min_interval_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        prev_edge_q <= now;
      end
      if (report) begin
        last_speed_q <= speed_q;
        last_report_q <= now_q;
        out_valid_q <= 1'b1;
      end else if (!speed_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    if (accept) begin
      now_q <= now;
    end
    if (report) begin
      out_data_q <= speed_q;
    end
  end

  assign speed_valid_o = out_valid_q;
  assign wheel_kmh_o = out_data_q;

endmodule

`default_nettype wire

// ===== tb/tb_wheel_speed_from_edge_period.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel speed from edge period testbench
// Feeds edge timestamps and register settings to the block and checks every
// reported speed against a directed value or an in-bench model of the period
// division and report rules, random idling at both ends, one long output hold.
// ----------------------------------------------------------------------------

module tb_wheel_speed_from_edge_period;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned HoldAtItem = 200;
  localparam int unsigned HoldCycles = 600;

  typedef logic [wsp_pkg::FieldBits-1:0] field_t;

  typedef enum logic [1:0] {
    EdgeByModel,
    EdgeNoSpeed,
    EdgeSpeed,
    CfgWrite
  } row_op_e;

  typedef struct packed {
    row_op_e                        op;
    logic [wsp_pkg::CfgIdxBits-1:0] index;
    field_t                         value;
    field_t                         speed;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [wsp_pkg::CfgIdxBits-1:0] cfg_index_i = '0;
  field_t                         cfg_data_i = '0;
  logic                           edge_valid_i = 1'b0;
  logic                           edge_stall_o;
  field_t                         edge_time_i = '0;
  logic                           speed_valid_o;
  logic                           speed_stall_i = 1'b0;
  field_t                         wheel_kmh_o;

  field_t      numerator_q;
  field_t      interval_q;
  field_t      prev_stamp_q;
  field_t      report_stamp_q;
  field_t      reported_speed_q;
  field_t      speed_queue[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned edges_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          steady = 1'b0;
  field_t      last_stamp = '0;

  wheel_speed_from_edge_period DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .edge_valid_i (edge_valid_i),
    .edge_stall_o (edge_stall_o),
    .edge_time_i  (edge_time_i),
    .speed_valid_o(speed_valid_o),
    .speed_stall_i(speed_stall_i),
    .wheel_kmh_o  (wheel_kmh_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input field_t got, input field_t want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Updates the model state for one edge and tells whether a speed is reported.
  function automatic bit speed_for_stamp(input field_t stamp, output field_t speed);
    field_t period;
    field_t elapsed;
    period = stamp - prev_stamp_q;
    elapsed = stamp - report_stamp_q;
    prev_stamp_q = stamp;
    speed = '0;
    if (elapsed < interval_q) return 1'b0;
    speed = (period == '0) ? wsp_pkg::SpeedMax : field_t'(numerator_q / period);
    if (speed == reported_speed_q) return 1'b0;
    reported_speed_q = speed;
    report_stamp_q = stamp;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (speed_valid_o && !speed_stall_i) begin
        if (speed_queue.size() == 0) begin
          report_mismatch("speed item with none expected", wheel_kmh_o, '0);
        end else begin
          field_t want;
          want = speed_queue.pop_front();
          if (wheel_kmh_o !== want) report_mismatch("wheel_kmh", wheel_kmh_o, want);
        end
      end
      if (edge_valid_i && !edge_stall_o) edges_seen <= edges_seen + 1;
      if (hold_left != 0) begin
        speed_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (edges_seen == HoldAtItem && !hold_done) begin
        speed_stall_i <= 1'b1;
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else begin
        speed_stall_i <= !steady && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic offer_edge(input field_t stamp, input row_op_e op, input field_t speed);
    field_t model_speed;
    bit     emit;
    while (!steady && $urandom_range(99) < 26) begin
      edge_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    edge_valid_i <= 1'b1;
    edge_time_i <= stamp;
    @(posedge clk_i);
    while (edge_stall_o) @(posedge clk_i);
    emit = speed_for_stamp(stamp, model_speed);
    if (op == EdgeSpeed) speed_queue.push_back(speed);
    else if (op == EdgeByModel && emit) speed_queue.push_back(model_speed);
    last_stamp = stamp;
  endtask

  task automatic wait_quiet();
    edge_valid_i <= 1'b0;
    while (speed_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wsp_pkg::CfgIdxBits-1:0] index, input field_t value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == wsp_pkg::RegSpeedNumerator) numerator_q = value;
    else if (index == wsp_pkg::RegMinInterval) interval_q = value;
    @(posedge clk_i);
  endtask

  function automatic field_t next_stamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return last_stamp;
    if (pick < 24) return last_stamp + field_t'($urandom_range(1, 255));
    if (pick < 74) return last_stamp + field_t'($urandom_range(256, 65535));
    if (pick < 90) return last_stamp + field_t'($urandom_range(65536, wsp_pkg::SpeedMax));
    return field_t'($urandom);
  endfunction

  initial begin
    numerator_q = wsp_pkg::SpeedNumeratorReset;
    interval_q = wsp_pkg::MinIntervalReset;
    prev_stamp_q = '0;
    report_stamp_q = '0;
    reported_speed_q = '0;

    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h000000, '0});
    directed_rows.push_back('{EdgeSpeed, '0, 24'h004000, 24'd14});
    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h008000, '0});
    directed_rows.push_back('{EdgeSpeed, '0, 24'h008000, wsp_pkg::SpeedMax});
    directed_rows.push_back('{EdgeSpeed, '0, 24'hFFFFFF, 24'd0});
    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h000100, '0});
    directed_rows.push_back('{CfgWrite, wsp_pkg::RegMinInterval, 24'd0, '0});
    directed_rows.push_back('{CfgWrite, wsp_pkg::RegSpeedNumerator, wsp_pkg::SpeedMax, '0});
    directed_rows.push_back('{EdgeSpeed, '0, 24'h000101, wsp_pkg::SpeedMax});
    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h000101, '0});
    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h000102, '0});
    directed_rows.push_back('{EdgeByModel, '0, 24'h000104, '0});
    directed_rows.push_back('{EdgeByModel, '0, 24'h7FFFFF, '0});
    directed_rows.push_back('{CfgWrite, wsp_pkg::RegSpeedNumerator, 24'd0, '0});
    directed_rows.push_back('{EdgeSpeed, '0, 24'h000200, 24'd0});
    directed_rows.push_back('{EdgeNoSpeed, '0, 24'h000300, '0});
    directed_rows.push_back('{EdgeSpeed, '0, 24'h000300, wsp_pkg::SpeedMax});
    directed_rows.push_back('{CfgWrite, wsp_pkg::RegSpeedNumerator, 24'd1, '0});
    directed_rows.push_back('{CfgWrite, wsp_pkg::RegMinInterval, wsp_pkg::SpeedMax, '0});
    directed_rows.push_back('{EdgeByModel, '0, 24'hAAAAAA, '0});
    directed_rows.push_back('{EdgeByModel, '0, 24'h555555, '0});
    directed_rows.push_back('{EdgeByModel, '0, 24'h0002FF, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == CfgWrite) begin
        wait_quiet();
        write_reg(directed_rows[i].index, directed_rows[i].value);
      end else begin
        offer_edge(directed_rows[i].value, directed_rows[i].op, directed_rows[i].speed);
      end
    end

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      wait_quiet();
      steady <= (phase == 1);
      case (phase)
        0: begin
          write_reg(wsp_pkg::RegSpeedNumerator, wsp_pkg::SpeedNumeratorReset);
          write_reg(wsp_pkg::RegMinInterval, wsp_pkg::MinIntervalReset);
        end
        1: begin
          write_reg(wsp_pkg::RegSpeedNumerator, wsp_pkg::SpeedMax);
          write_reg(wsp_pkg::RegMinInterval, 24'd0);
        end
        2: begin
          write_reg(wsp_pkg::RegSpeedNumerator, field_t'($urandom));
          write_reg(wsp_pkg::RegMinInterval, field_t'($urandom_range(0, 4095)));
        end
        3: begin
          write_reg(wsp_pkg::RegSpeedNumerator, 24'd1);
          write_reg(wsp_pkg::RegMinInterval, 24'd0);
        end
        4: begin
          write_reg(wsp_pkg::RegSpeedNumerator, field_t'($urandom));
          write_reg(wsp_pkg::RegMinInterval,
                    field_t'($urandom_range(1048576, wsp_pkg::SpeedMax)));
        end
        default: begin
          write_reg(wsp_pkg::RegSpeedNumerator, field_t'($urandom));
          write_reg(wsp_pkg::RegMinInterval, field_t'($urandom_range(0, 65535)));
        end
      endcase
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2 && phase == 2) wait_quiet();
        offer_edge(next_stamp(), EdgeByModel, '0);
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
